@@ sv/bgwb_pkg.sv @@
// Shared types, constants and site decode for the grey-world white balance block.
package bgwb_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned GREEN_W    = SUM_W + 1;
  localparam int unsigned DIVIDEND_W = GREEN_W + FRAC_W;
  localparam int unsigned DIVISOR_W  = SUM_W + 1;
  localparam int unsigned QUOT_W     = GAIN_W + 1;
  localparam int unsigned DSH_W      = DIVISOR_W + GAIN_W;
  localparam int unsigned PROD_W     = PIX_W + GAIN_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << FRAC_W);
  localparam logic [GAIN_W-1:0] GAIN_SAT   = '1;
  localparam logic [PIX_W-1:0]  MAX_LEVEL_RST = 16'd4095;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAYER_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 1'b1;

  // mosaic orders
  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_BGGR = 2'd1;
  localparam logic [1:0] PAT_GBRG = 2'd2;

  typedef enum logic [1:0] {
    SITE_R  = 2'd0,
    SITE_GR = 2'd1,
    SITE_GB = 2'd2,
    SITE_B  = 2'd3
  } site_e;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
    logic             row_odd;
    logic             col_odd;
    logic             frame_last;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [PIX_W-1:0]  blue_out;
    logic [PIX_W-1:0]  green_out;
    logic [PIX_W-1:0]  red_out;
    logic [GAIN_W-1:0] red_gain_out;
    logic [GAIN_W-1:0] blue_gain_out;
  } out_word_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Site of a pixel from mosaic order and row/column parity; code 3 acts as RGGB.
  function automatic site_e site_of(input logic [1:0] pattern, input logic row_odd,
                                    input logic col_odd);
    logic [1:0] pos;
    site_e      s;
    pos = {row_odd, col_odd};
    case (pattern)
      PAT_BGGR: s = site_e'(pos ^ 2'b11);
      PAT_GBRG: s = site_e'(pos ^ 2'b10);
      default:  s = site_e'(pos);
    endcase
    return s;
  endfunction

endpackage

@@ sv/bgwb_div.sv @@
// Shared restoring divider: one quotient bit per cycle, saturating 16-bit result.
module bgwb_div
  import bgwb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_ctrl_t         ctrl_i,
  output div_stat_t         stat_o,
  output logic [GAIN_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0]      dsh_q, dsh_d;
  logic [QUOT_W-1:0]     quo_q, quo_d;
  logic                  ge;

  // divisor starts at bit GAIN_W: a one in the top quotient bit means saturation
  // (a zero divisor always sets it)
  assign ge = {{(DSH_W-DIVIDEND_W){1'b0}}, rem_q} >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W - 1);
      rem_d  = ctrl_i.dividend;
      dsh_d  = {ctrl_i.divisor, {GAIN_W{1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q[DIVIDEND_W-1:0];
      end
      quo_d = {quo_q[QUOT_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o = quo_q[QUOT_W-1] ? GAIN_SAT : quo_q[GAIN_W-1:0];

endmodule

@@ sv/bayer_grey_world_white_balance_unit.sv @@
// Top level: grey-world white balance on a twice-streamed raw Bayer frame.
// Gather word (not last): summed at once, no result; one word per cycle while the unit is idle.
// Correct word: the 16x16 product is registered, then shifted and clamped into the output register
//   once that is free; the input stays closed until then.
// Last gather word: green sums added, then the shared 17-step divider runs for red, then blue.
// Reset (async, low): sums zero, gains 1024, pattern RGGB, max_level 4095, output empty.
module bayer_grey_world_white_balance_unit
  import bgwb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take words, accumulate gather pixels
  localparam logic [2:0] ST_MUL   = 3'd1;  // product ready, shift/clamp into output
  localparam logic [2:0] ST_SUM   = 3'd2;  // add the two green sums
  localparam logic [2:0] ST_DIV_R = 3'd3;  // red gain on the divider
  localparam logic [2:0] ST_DIV_B = 3'd4;  // blue gain on the divider, then clear sums
  localparam logic [2:0] ST_GAIN  = 3'd5;  // hand out the gain word

  logic [2:0]        state_q, state_d;

  // configuration
  logic [1:0]        pattern_q;
  logic [PIX_W-1:0]  max_level_q;

  // statistics
  logic [SUM_W-1:0]  sum_r_q, sum_gr_q, sum_gb_q, sum_b_q;
  logic [SUM_W-1:0]  sum_r_d, sum_gr_d, sum_gb_d, sum_b_d;
  logic [GREEN_W-1:0] green_q;
  logic [GAIN_W-1:0] red_gain_q, blue_gain_q;

  // correct path
  logic [PROD_W-1:0] prod_q;
  logic [PIX_W-1:0]  pix_q;
  site_e             site_q;

  // output register
  logic              out_valid_q;
  out_word_t         out_word_q;
  logic              out_load;
  out_word_t         out_next;
  logic              out_free;

  // divider hookup
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic [GAIN_W-1:0] div_quot;

  logic              in_acc;
  site_e             in_site;
  logic [GAIN_W-1:0] in_gain;
  logic [PROD_W-FRAC_W-1:0] scaled;
  logic [PIX_W-1:0]  clamped;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_site    = site_of(pattern_q, in_word_i.row_odd, in_word_i.col_odd);
  assign in_gain    = (in_site == SITE_B) ? blue_gain_q : red_gain_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // gained red/blue: drop the fraction, clamp to max_level
  assign scaled  = prod_q[PROD_W-1:FRAC_W];
  assign clamped = (scaled > {{(PROD_W-FRAC_W-PIX_W){1'b0}}, max_level_q}) ?
                   max_level_q : scaled[PIX_W-1:0];

  // divider runs red first, then blue; start fires on the first cycle of each state
  always_comb begin
    div_ctrl.start    = (state_q == ST_DIV_R || state_q == ST_DIV_B) &&
                        !div_stat.busy && !div_stat.done;
    div_ctrl.dividend = {green_q, {FRAC_W{1'b0}}};
    div_ctrl.divisor  = (state_q == ST_DIV_B) ? {sum_b_q, 1'b0} : {sum_r_q, 1'b0};
  end

  bgwb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d  = state_q;
    sum_r_d  = sum_r_q;
    sum_gr_d = sum_gr_q;
    sum_gb_d = sum_gb_q;
    sum_b_d  = sum_b_q;
    out_load = 1'b0;
    out_next = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_word_i.func) begin
            case (in_site)
              SITE_R:  sum_r_d  = sum_r_q  + SUM_W'(in_word_i.pixel);
              SITE_GR: sum_gr_d = sum_gr_q + SUM_W'(in_word_i.pixel);
              SITE_GB: sum_gb_d = sum_gb_q + SUM_W'(in_word_i.pixel);
              default: sum_b_d  = sum_b_q  + SUM_W'(in_word_i.pixel);
            endcase
            if (in_word_i.frame_last) begin
              state_d = ST_SUM;
            end
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (out_free) begin
          out_load = 1'b1;
          case (site_q)
            SITE_R:  out_next.red_out   = clamped;
            SITE_B:  out_next.blue_out  = clamped;
            default: out_next.green_out = pix_q;
          endcase
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        state_d = ST_DIV_R;
      end
      ST_DIV_R: begin
        if (div_stat.done) begin
          state_d = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_stat.done) begin
          sum_r_d  = '0;
          sum_gr_d = '0;
          sum_gb_d = '0;
          sum_b_d  = '0;
          state_d  = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_next.kind          = 1'b1;
          out_next.red_gain_out  = red_gain_q;
          out_next.blue_gain_out = blue_gain_q;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pattern_q   <= PAT_RGGB;
      max_level_q <= MAX_LEVEL_RST;
      sum_r_q     <= '0;
      sum_gr_q    <= '0;
      sum_gb_q    <= '0;
      sum_b_q     <= '0;
      red_gain_q  <= UNITY_GAIN;
      blue_gain_q <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_r_q  <= sum_r_d;
      sum_gr_q <= sum_gr_d;
      sum_gb_q <= sum_gb_d;
      sum_b_q  <= sum_b_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BAYER_PATTERN: pattern_q   <= cfg_data_i[1:0];
          CFG_MAX_LEVEL:     max_level_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DIV_R && div_stat.done) begin
        red_gain_q <= div_quot;
      end
      if (state_q == ST_DIV_B && div_stat.done) begin
        blue_gain_q <= div_quot;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.func) begin
      prod_q <= PROD_W'(in_word_i.pixel) * PROD_W'(in_gain);
      pix_q  <= in_word_i.pixel;
      site_q <= in_site;
    end
    if (state_q == ST_SUM) begin
      green_q <= {1'b0, sum_gr_q} + {1'b0, sum_gb_q};
    end
    if (out_load) begin
      out_word_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ sv/bgwb_checker.sv @@
// Port-level checks for the white balance unit, bound to the top level.
module bgwb_checker
  import bgwb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_word_t              in_word_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_word_t             out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // gain words carry no pixel channel
  a_gain_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind |->
      out_word_o.red_out == '0 && out_word_o.green_out == '0 &&
      out_word_o.blue_out == '0)
    else $error("gain word with pixel data");

  // pixel words carry no gains and at most one channel
  a_pixel_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.kind |->
      out_word_o.red_gain_out == '0 && out_word_o.blue_gain_out == '0 &&
      $countones({out_word_o.red_out != '0, out_word_o.green_out != '0,
                  out_word_o.blue_out != '0}) <= 1)
    else $error("malformed pixel word");

  // a correct word or last gather word keeps the input closed the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.func || in_word_i.frame_last) |=> !in_ready_o)
    else $error("input reopened during multi-cycle work");

endmodule

bind bayer_grey_world_white_balance_unit bgwb_checker u_bgwb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
